@@ rtl/dscp_pkg.sv @@
// shared types and constants for the 8.3 short name check and pack block
// no dependencies

package dscp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned BaseLen = 8;
  localparam int unsigned ExtLen  = 3;

  localparam logic [ByteW-1:0] ChNul      = 8'h00;
  localparam logic [ByteW-1:0] ChSpace    = 8'h20;
  localparam logic [ByteW-1:0] ChDot      = 8'h2E;
  localparam logic [ByteW-1:0] ChSlash    = 8'h2F;
  localparam logic [ByteW-1:0] ChTilde    = 8'h7E;
  localparam logic [ByteW-1:0] ChDollar   = 8'h24;
  localparam logic [ByteW-1:0] CaseOffset = 8'h20;  // 'a' - 'A'

  typedef logic [BaseLen-1:0][ByteW-1:0] base_t;
  typedef logic [ExtLen-1:0][ByteW-1:0]  ext_t;

  localparam base_t SpaceBase = {BaseLen{ChSpace}};
  localparam ext_t  SpaceExt  = {ExtLen{ChSpace}};

  // byte classification handed from the classifier to the name state
  typedef struct packed {
    logic             is_end;
    logic             is_dot;
    logic             allowed;
    logic [ByteW-1:0] ch_up;
  } cls_t;

  // packed name as seen at an end byte
  typedef struct packed {
    logic  name_ok;
    base_t base;
    ext_t  ext;
  } res_t;

endpackage

@@ rtl/dscp_classify.sv @@
// byte classifier: end and dot detection, case folding, allowed set check
// depends on dscp_pkg

module dscp_classify (
  input  logic [dscp_pkg::ByteW-1:0] ch_i,
  output dscp_pkg::cls_t             cls_o
);
  import dscp_pkg::*;

  logic [ByteW-1:0] up;
  logic             ok;

  always_comb begin
    up = ch_i;
    if (ch_i inside {[8'h61:8'h7A]}) begin
      up = ch_i - CaseOffset;
    end
  end

  always_comb begin
    ok = 1'b0;
    if (up[ByteW-1]) begin
      ok = 1'b1;
    end else if (up inside {[8'h41:8'h5A], [8'h30:8'h39]}) begin
      ok = 1'b1;
    end else if (up inside {ChDollar, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, ChTilde,
                            8'h60, 8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E,
                            8'h23, 8'h26, ChSpace}) begin
      ok = 1'b1;
    end
  end

  assign cls_o.is_end  = (ch_i == ChNul) || (ch_i == ChSlash);
  assign cls_o.is_dot  = (ch_i == ChDot);
  assign cls_o.allowed = ok;
  assign cls_o.ch_up   = up;

endmodule

@@ rtl/dscp_name_state.sv @@
// name state: base and extension stores, lengths, dot and error flags
// depends on dscp_pkg

module dscp_name_state (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  dscp_pkg::cls_t cls_i,
  output dscp_pkg::res_t res_o
);
  import dscp_pkg::*;

  logic [3:0] base_len_q, base_len_d;
  logic [1:0] ext_len_q, ext_len_d;
  logic       dot_q, dot_d;
  logic       bad_q, bad_d;
  base_t      base_q, base_d;
  ext_t       ext_q, ext_d;
  logic [2:0] base_idx;
  logic [1:0] ext_idx;

  assign base_idx = 3'(BaseLen - 1) - base_len_q[2:0];
  assign ext_idx  = 2'(ExtLen - 1) - ext_len_q;

  always_comb begin
    base_len_d = base_len_q;
    ext_len_d  = ext_len_q;
    dot_d      = dot_q;
    bad_d      = bad_q;
    base_d     = base_q;
    ext_d      = ext_q;
    if (step_i) begin
      if (cls_i.is_end) begin
        base_len_d = '0;
        ext_len_d  = '0;
        dot_d      = 1'b0;
        bad_d      = 1'b0;
        base_d     = SpaceBase;
        ext_d      = SpaceExt;
      end else if (!bad_q) begin
        if (cls_i.is_dot) begin
          if (dot_q) begin
            bad_d = 1'b1;
          end else begin
            dot_d = 1'b1;
          end
        end else if (!cls_i.allowed) begin
          bad_d = 1'b1;
        end else if (!dot_q) begin
          if (base_len_q[3]) begin
            bad_d = 1'b1;
          end else begin
            base_d[base_idx] = cls_i.ch_up;
            base_len_d       = base_len_q + 4'd1;
          end
        end else begin
          if (base_len_q == 4'd0 || ext_len_q == 2'(ExtLen)) begin
            bad_d = 1'b1;
          end else begin
            ext_d[ext_idx] = cls_i.ch_up;
            ext_len_d      = ext_len_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q <= '0;
      ext_len_q  <= '0;
      dot_q      <= 1'b0;
      bad_q      <= 1'b0;
      base_q     <= SpaceBase;
      ext_q      <= SpaceExt;
    end else begin
      base_len_q <= base_len_d;
      ext_len_q  <= ext_len_d;
      dot_q      <= dot_d;
      bad_q      <= bad_d;
      base_q     <= base_d;
      ext_q      <= ext_d;
    end
  end

  assign res_o.name_ok = !bad_q;
  assign res_o.base    = bad_q ? '0 : base_q;
  assign res_o.ext     = bad_q ? '0 : ext_q;

`ifndef SYNTHESIS
  a_ext_needs_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dot_q |-> ext_len_q == 2'd0)
    else $error("extension length grew without a dot");
  a_base_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_len_q <= 4'(BaseLen))
    else $error("base length beyond limit");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cls_i.is_end |=> base_len_q == 4'd0 && !dot_q && !bad_q)
    else $error("name state not cleared after end byte");
`endif

endmodule

@@ rtl/dos_short_name_check_pack.sv @@
// top level of the 8.3 short name check and pack block
// depends on dscp_pkg, dscp_classify, dscp_name_state
//
// usage:
//   - input channel (in_valid_i / in_ready_o / ch_i) takes one filename byte
//     per request; a byte of 0x00 or '/' ends the name
//   - output channel (out_valid_o / out_ready_i) gives one result per end byte:
//     valid_res_o, base_chars_o (first char in the top byte) and ext_chars_o,
//     both space padded; an illegal name gives valid_res_o low and zero fields
//   - bytes other than the end byte produce no result
//   - timing: a byte is held in the input register, then the name state
//     updates; the result of an end byte is loaded into the result register
//     as the end byte leaves the input register, and is offered from there
//   - throughput: one byte per cycle while no end byte waits for a result slot,
//     set by the classifier and state update between the input and result registers
//   - a stalled receiver only holds up an end byte waiting in the input
//     register; ordinary bytes keep flowing while the result waits
//   - reset empties both registers and returns the name state to an empty
//     name with an all-space base and extension

module dos_short_name_check_pack (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dscp_pkg::ByteW-1:0]          ch_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                valid_res_o,
  output logic [dscp_pkg::BaseLen*dscp_pkg::ByteW-1:0] base_chars_o,
  output logic [dscp_pkg::ExtLen*dscp_pkg::ByteW-1:0]  ext_chars_o
);
  import dscp_pkg::*;

  // input register
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] ch_q;

  // result register
  logic out_vld_q, out_vld_d;
  res_t res_q;

  cls_t cls;
  res_t cur_res;
  logic out_free;
  logic step;
  logic in_take;

  dscp_classify u_classify (
    .ch_i  (ch_q),
    .cls_o (cls)
  );

  dscp_name_state u_name_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cls_i  (cls),
    .res_o  (cur_res)
  );

  // an end byte needs a free result slot, other bytes always advance
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && (!cls.is_end || out_free);
  assign in_ready_o = !in_vld_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step && cls.is_end) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q <= ch_i;
    end
    if (step && cls.is_end) begin
      res_q <= cur_res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign valid_res_o  = res_q.name_ok;
  assign base_chars_o = res_q.base;
  assign ext_chars_o  = res_q.ext;

`ifndef SYNTHESIS
  a_stall_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && cls.is_end && out_vld_q && !out_ready_i)
    else $error("input stalled without a blocked end byte");
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.name_ok |-> res_q.base == '0 && res_q.ext == '0)
    else $error("illegal name result carries nonzero fields");
  a_end_makes_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && cls.is_end |=> out_vld_q)
    else $error("end byte did not load the result register");
`endif

endmodule

@@ dv/testbench.sv @@
// testbench for the 8.3 short name check and pack block: byte stream in, packed names out
// depends on dscp_pkg and dos_short_name_check_pack from the rtl folder

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dscp_pkg::*;

  // bytes that may appear in a short name besides letters, digits and high bytes
  localparam logic [ByteW-1:0] LegalPunct [17] = '{
    ChDollar, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, ChTilde, 8'h60, 8'h21,
    8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26, ChSpace
  };

  // hand-picked names: empty name, lone dot, full-length name with extremes and
  // lower case, trailing dot, extension without base, second dot, forbidden byte
  localparam logic [ByteW-1:0] DirectedBytes [29] = '{
    ChNul,
    ChDot, ChSlash,
    8'h61, 8'h5A, 8'h30, 8'h39, ChTilde, ChDollar, 8'h80, 8'hFF,
    ChDot, 8'h7A, 8'h60, ChSpace, ChNul,
    8'h41, 8'h42, ChDot, ChSlash,
    ChDot, 8'h58, ChNul,
    8'h41, ChDot, ChDot, ChSlash,
    8'h2A, ChNul
  };

  // one pending request; the flag makes the sender wait for all results first
  typedef struct {
    logic [ByteW-1:0] ch;
    bit               hold_for_drain;
  } name_byte_t;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic [ByteW-1:0]            ch_i         = ChNul;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic                        valid_res_o;
  logic [BaseLen*ByteW-1:0]    base_chars_o;
  logic [ExtLen*ByteW-1:0]     ext_chars_o;

  name_byte_t pending_q [$];   // bytes waiting for the driver
  res_t       exp_names [$];   // packed names still owed by the block
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         fed_bytes     = 0;
  int         errors        = 0;

  // name state of the predictor
  int    nm_base_cnt = 0;
  int    nm_ext_cnt  = 0;
  bit    nm_dot      = 1'b0;
  bit    nm_bad      = 1'b0;
  base_t nm_base     = SpaceBase;
  ext_t  nm_ext      = SpaceExt;

  dos_short_name_check_pack u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .valid_res_o  (valid_res_o),
    .base_chars_o (base_chars_o),
    .ext_chars_o  (ext_chars_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // advance the predicted name by one accepted byte
  task automatic pack_name_byte(input logic [ByteW-1:0] raw);
    logic [ByteW-1:0] c;
    bit               legal;
    c = raw;
    if (c == ChNul || c == ChSlash) begin
      // end of name: one result, then back to an empty name
      if (nm_bad) begin
        exp_names.push_back('{name_ok: 1'b0, base: '0, ext: '0});
      end else begin
        exp_names.push_back('{name_ok: 1'b1, base: nm_base, ext: nm_ext});
      end
      nm_base_cnt = 0;
      nm_ext_cnt  = 0;
      nm_dot      = 1'b0;
      nm_bad      = 1'b0;
      nm_base     = SpaceBase;
      nm_ext      = SpaceExt;
    end else if (!nm_bad) begin
      if (c == ChDot) begin
        // a second dot spoils the name
        if (nm_dot) nm_bad = 1'b1;
        else nm_dot = 1'b1;
      end else begin
        if (c inside {[8'h61:8'h7A]}) c = c - CaseOffset;
        legal = (c >= 8'h80) || (c inside {[8'h41:8'h5A], [8'h30:8'h39]});
        foreach (LegalPunct[i]) if (c == LegalPunct[i]) legal = 1'b1;
        if (!legal) begin
          nm_bad = 1'b1;
        end else if (!nm_dot) begin
          if (nm_base_cnt >= BaseLen) begin
            nm_bad = 1'b1;
          end else begin
            nm_base[BaseLen-1-nm_base_cnt] = c;
            nm_base_cnt++;
          end
        end else if (nm_base_cnt == 0 || nm_ext_cnt >= ExtLen) begin
          // extension with no base, or a fourth extension byte
          nm_bad = 1'b1;
        end else begin
          nm_ext[ExtLen-1-nm_ext_cnt] = c;
          nm_ext_cnt++;
        end
      end
    end
  endtask

  // driver: note the accepted request, then offer the next one or idle
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    name_byte_t       req;
    logic             nxt_valid;
    logic [ByteW-1:0] nxt_ch;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i       <= ChNul;
    end else begin
      nxt_valid = in_valid_i;
      nxt_ch    = ch_i;
      if (in_valid_i && in_ready_o) begin
        pack_name_byte(ch_i);
        nxt_valid = 1'b0;
      end
      // a marked byte is held back until every owed result has come out
      if (!nxt_valid && pending_q.size() != 0 &&
          $urandom_range(99) >= send_idle_pct &&
          !(pending_q[0].hold_for_drain && exp_names.size() != 0)) begin
        req       = pending_q.pop_front();
        nxt_valid = 1'b1;
        nxt_ch    = req.ch;
      end
      in_valid_i <= nxt_valid;
      ch_i       <= nxt_ch;
    end
  end

  // monitor: check each taken result against the oldest predicted name
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (exp_names.size() == 0) begin
          flag_error($sformatf("unexpected result ok=%0b base=%h ext=%h",
                               valid_res_o, base_chars_o, ext_chars_o));
        end else begin
          want = exp_names.pop_front();
          if (valid_res_o !== want.name_ok || base_chars_o !== want.base ||
              ext_chars_o !== want.ext) begin
            flag_error($sformatf("got ok=%0b base=%h ext=%h, want ok=%0b base=%h ext=%h",
                                 valid_res_o, base_chars_o, ext_chars_o,
                                 want.name_ok, want.base, want.ext));
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [ByteW-1:0] pick_legal_byte();
    case ($urandom_range(4))
      0:       return 8'h41 + ByteW'($urandom_range(25));   // upper case
      1:       return 8'h61 + ByteW'($urandom_range(25));   // lower case, folded
      2:       return 8'h30 + ByteW'($urandom_range(9));
      3:       return 8'h80 + ByteW'($urandom_range(127));
      default: return LegalPunct[$urandom_range(16)];
    endcase
  endfunction

  // one name: mostly well formed with random content, some broken or noise
  task automatic queue_random_name(input bit hold_first);
    logic [ByteW-1:0] name_q [$];
    int               n_base;
    int               n_ext;
    int               n_noise;
    bit               with_dot;
    if ($urandom_range(32) == 0) begin
      // pure noise, any byte value
      n_noise = $urandom_range(1, 12);
      repeat (n_noise) name_q.push_back(ByteW'($urandom_range(255)));
    end else begin
      // lengths reach one past the limits now and then
      n_base   = ($urandom_range(9) == 0) ? $urandom_range(9) : $urandom_range(1, 8);
      with_dot = ($urandom_range(3) != 0);
      n_ext    = !with_dot ? 0 :
                 ($urandom_range(7) == 0) ? $urandom_range(4) : $urandom_range(3);
      repeat (n_base) name_q.push_back(pick_legal_byte());
      if (with_dot) name_q.push_back(ChDot);
      repeat (n_ext) name_q.push_back(pick_legal_byte());
      if ($urandom_range(9) == 0)
        name_q.insert($urandom_range(name_q.size()), ByteW'($urandom_range(255)));
      if ($urandom_range(14) == 0)
        name_q.insert($urandom_range(name_q.size()), ChDot);
    end
    name_q.push_back($urandom_range(1) ? ChNul : ChSlash);
    foreach (name_q[i]) begin
      pending_q.push_back('{ch: name_q[i], hold_for_drain: (i == 0) && hold_first});
      fed_bytes++;
    end
  endtask

  // one idling setting: feed bytes, then let every owed result come out
  task automatic run_phase(input int send_pct, input int recv_pct, input int target,
                           input bit with_directed);
    int n;
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_directed) begin
      foreach (DirectedBytes[i]) begin
        pending_q.push_back('{ch: DirectedBytes[i], hold_for_drain: 1'b0});
        fed_bytes++;
      end
    end
    // the first name of a phase always waits for the block to drain
    queue_random_name(1'b1);
    while (fed_bytes < target) queue_random_name($urandom_range(24) == 0);
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    for (n = 0; exp_names.size() != 0 && n < 400; n++) @(posedge clk_i);
    if (exp_names.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", exp_names.size()));
      exp_names.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // sender rarely idle, receiver mostly stalled; then the other way round;
    // then full rate on both sides
    run_phase(9, 63, 420, 1'b1);
    run_phase(63, 9, 840, 1'b0);
    run_phase(0, 0, 1260, 1'b0);
    if (errors == 0) begin
      $display("dos_short_name_check_pack regression: pass");
    end else begin
      $display("dos_short_name_check_pack regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("dos_short_name_check_pack regression: fail");
    $finish;
  end

endmodule
